// ----- rtl/core/wpma_pkg.sv -----
package wpma_pkg;

  // item field widths
  localparam int ACT_W   = 2;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int KERN_W     = 4;
  localparam int PAD_W      = 3;
  localparam int PLANE_W    = 7;

  // signed window coordinates: row * stride - pad + kernel offset
  localparam int CRD_W = 12;

  // actions
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MAX  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_AVG  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_H  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_W  = 3'd7;

endpackage

// ----- rtl/core/wpma_in_if.sv -----
interface wpma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import wpma_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [ACT_W-1:0]              action;
  logic [POS_W-1:0]              row;
  logic [POS_W-1:0]              col;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, action, row, col, sample, input ready);
  modport sink (input valid, action, row, col, sample, output ready);

endinterface

// ----- rtl/core/wpma_out_if.sv -----
interface wpma_out_if #(
  parameter int SAMPLE_BITS = 16
);
  import wpma_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic [COUNT_W-1:0]            valid_count;

  modport source (output valid, pooled_value, valid_count, input ready);
  modport sink (input valid, pooled_value, valid_count, output ready);

endinterface

// ----- rtl/core/wpma_ram.sv -----
module wpma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/wpma_div.sv -----
module wpma_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0]        denom,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic              neg;
  logic [DEN_W:0]    trial;
  logic              fits;

  // restoring division of the magnitude, one quotient bit a cycle
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= STEP_W'(NUM_W);
      den   <= denom;
      rem   <= '0;
      neg   <= numer[NUM_W-1];
      quo   <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ----- rtl/core/window_pool_max_avg.sv -----
// channel    dir  handshake        payload
// pool_in    in   valid / ready    action, row, col, sample
// pool_out   out  valid / ready    pooled_value, valid_count
// cfg        in   cfg_we only      cfg_index, cfg_data
//
// a load item is written to the store in idle; a compute item walks the kh*kw window (S_RUN), then
// passes S_DRAIN and S_POST, waits in S_DIV for the divider on an average with valid positions,
// and hands its result over in S_FIN; a zero kernel skips the walk and goes straight to S_POST
// the window walk reads one plane store entry a cycle through its single read port
// reset is synchronous and clears the sequencer and the registers; the store is not cleared
// pool_in is ready whenever the sequencer is idle, also while a result waits on pool_out
module window_pool_max_avg #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [wpma_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wpma_pkg::CFG_DATA_W-1:0]        cfg_data,
  wpma_in_if.sink                                pool_in,
  wpma_out_if.source                             pool_out
);
  import wpma_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int K_W   = $clog2(MAX_KERNEL + 1);
  localparam int CNT_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int ACC_W = SAMPLE_BITS + CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // configuration registers
  logic [KERN_W-1:0]  kernel_height, kernel_width, stride_rows, stride_cols;
  logic [PAD_W-1:0]   pad_top, pad_left;
  logic [PLANE_W-1:0] plane_height, plane_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= KERN_W'(2);
      kernel_width  <= KERN_W'(2);
      stride_rows   <= KERN_W'(2);
      stride_cols   <= KERN_W'(2);
      pad_top       <= '0;
      pad_left      <= '0;
      plane_height  <= PLANE_W'(64);
      plane_width   <= PLANE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_H: kernel_height <= cfg_data[KERN_W-1:0];
        REG_KERNEL_W: kernel_width  <= cfg_data[KERN_W-1:0];
        REG_STRIDE_R: stride_rows   <= cfg_data[KERN_W-1:0];
        REG_STRIDE_C: stride_cols   <= cfg_data[KERN_W-1:0];
        REG_PAD_TOP:  pad_top       <= cfg_data[PAD_W-1:0];
        REG_PAD_LEFT: pad_left      <= cfg_data[PAD_W-1:0];
        REG_PLANE_H:  plane_height  <= cfg_data[PLANE_W-1:0];
        REG_PLANE_W:  plane_width   <= cfg_data[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated kernel and plane sizes
  logic [K_W-1:0]     kh_n, kw_n;
  logic [PLANE_W-1:0] ph, pw;

  assign kh_n = (int'(kernel_height) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(kernel_height);
  assign kw_n = (int'(kernel_width) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(kernel_width);
  assign ph   = (int'(plane_height) > MAX_ROWS) ? PLANE_W'(MAX_ROWS) : plane_height;
  assign pw   = (int'(plane_width) > MAX_COLS) ? PLANE_W'(MAX_COLS) : plane_width;

  // sequencer and window walk registers
  logic [2:0]              state;
  logic [K_W-1:0]          kh, kw;
  logic signed [CRD_W-1:0] base_r, base_c;
  logic                    is_max;
  logic                    rd_pend;
  logic signed [ACC_W-1:0] acc;
  logic [CNT_W-1:0]        cnt;

  // result register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic [COUNT_W-1:0]            res_count;

  logic in_fire, is_compute, empty_win, last_pos, fin_fire;

  assign pool_in.ready = (state == S_IDLE);
  assign in_fire       = pool_in.valid && pool_in.ready;
  assign is_compute    = pool_in.action inside {ACT_MAX, ACT_AVG};
  assign empty_win     = (kh_n == '0) || (kw_n == '0);
  assign last_pos      = (kh == kh_n - K_W'(1)) && (kw == kw_n - K_W'(1));
  assign fin_fire      = (state == S_FIN) && (!out_valid || pool_out.ready);

  // current window position and its bounds test
  logic signed [CRD_W-1:0] ir, ic;
  logic                    pos_ok;

  assign ir     = base_r + $signed(CRD_W'(kh));
  assign ic     = base_c + $signed(CRD_W'(kw));
  assign pos_ok = !ir[CRD_W-1] && !ic[CRD_W-1]
               && (ir < $signed(CRD_W'(ph))) && (ic < $signed(CRD_W'(pw)));

  // plane store: loads write in idle, the walk reads one entry a cycle
  logic                   st_we;
  logic [AW-1:0]          st_waddr, st_raddr;
  logic [SAMPLE_BITS-1:0] st_rdata;

  assign st_we    = in_fire && (pool_in.action == ACT_LOAD)
                 && (int'(pool_in.row) < MAX_ROWS) && (int'(pool_in.col) < MAX_COLS);
  assign st_waddr = AW'(int'(pool_in.row) * MAX_COLS + int'(pool_in.col));
  assign st_raddr = AW'(int'(ir[RW-1:0]) * MAX_COLS + int'(ic[CW-1:0]));

  wpma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (pool_in.sample),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // shared accumulate unit: running max or running sum
  logic signed [ACC_W-1:0] s_ext, acc_min;

  assign s_ext   = {{CNT_W{st_rdata[SAMPLE_BITS-1]}}, st_rdata};
  assign acc_min = {{(CNT_W + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // serial divider for the average
  logic                    div_start, div_done;
  logic signed [ACC_W-1:0] div_quo;

  assign div_start = (state == S_POST) && !is_max && (cnt != '0);

  wpma_div #(
    .NUM_W (ACC_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (acc),
    .denom    (cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_RUN) && pos_ok;
      case (state)
        S_IDLE: begin
          if (in_fire && is_compute) begin
            state <= empty_win ? S_POST : S_RUN;
          end
        end
        S_RUN: begin
          if (last_pos) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_POST;
        S_POST:  state <= (is_max || cnt == '0) ? S_FIN : S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window walk, accumulate and result capture
  always_ff @(posedge clk) begin
    if (in_fire && is_compute) begin
      is_max <= (pool_in.action == ACT_MAX);
      base_r <= $signed(CRD_W'(pool_in.row) * CRD_W'(stride_rows) - CRD_W'(pad_top));
      base_c <= $signed(CRD_W'(pool_in.col) * CRD_W'(stride_cols) - CRD_W'(pad_left));
      kh     <= '0;
      kw     <= '0;
      cnt    <= '0;
      acc    <= (pool_in.action == ACT_MAX) ? acc_min : '0;
    end else begin
      if (state == S_RUN) begin
        if (kw == kw_n - K_W'(1)) begin
          kw <= '0;
          kh <= kh + K_W'(1);
        end else begin
          kw <= kw + K_W'(1);
        end
      end
      // data of the read issued last cycle
      if (rd_pend) begin
        cnt <= cnt + CNT_W'(1);
        if (is_max) begin
          acc <= (s_ext > acc) ? s_ext : acc;
        end else begin
          acc <= acc + s_ext;
        end
      end
    end

    if (state == S_POST) begin
      res_count <= COUNT_W'(cnt);
      res_value <= is_max ? acc[SAMPLE_BITS-1:0] : '0;
    end
    if (state == S_DIV && div_done) begin
      res_value <= div_quo[SAMPLE_BITS-1:0];
    end
  end

  // output register, freed when the sink takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (pool_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      pool_out.pooled_value <= res_value;
      pool_out.valid_count  <= res_count;
    end
  end

  assign pool_out.valid = out_valid;

  // count of valid positions never exceeds the window size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST) |-> (int'(cnt) <= int'(kh_n) * int'(kw_n)))
    else $error("valid count beyond window size");

  // every issued read has been consumed before the result is formed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST) |-> !rd_pend)
    else $error("window read still pending after drain");

  // the divider only finishes while the sequencer waits for it
  a_div_sync: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  // a new result only appears out of the finish state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside finish state");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wpma_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int MAX_KERNEL  = 8;

  // action code the block ignores
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // cycles to let the block settle after the last result
  localparam int SETTLE_CYCLES = 120;
  localparam int ITEM_TARGET   = 700;

  typedef struct packed {
    logic [ACT_W-1:0]       action;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic [SAMPLE_BITS-1:0] sample;
  } pool_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [COUNT_W-1:0]     count;
  } pool_result_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wpma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  wpma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  window_pool_max_avg #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pool_in  (in_ch),
    .pool_out (out_ch)
  );

  // shadow copy of the configuration registers
  logic [KERN_W-1:0]  kern_h, kern_w, step_r, step_c;
  logic [PAD_W-1:0]   pad_t, pad_l;
  logic [PLANE_W-1:0] rows_in, cols_in;

  // shadow plane, updated when a load item is accepted
  logic signed [SAMPLE_BITS-1:0] plane_mem [0:MAX_ROWS*MAX_COLS-1];
  // entries that some queued load will have written, used by the stimulus only
  bit filled [0:MAX_ROWS*MAX_COLS-1];

  pool_item_t   send_q[$];    // items waiting for the driver
  pool_result_t pooled_q[$];  // pooled values still owed by the block

  int  pushed_count, taken_count, stim_count;
  int  loads_taken, pools_checked, settings_done;
  int  fail_count;
  bit  calm;  // no idling on either side while set

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // valid window positions form a rectangle: clip the kernel against the plane
  function automatic void clip_window(input logic [POS_W-1:0] orow, ocol,
                                      output int r_lo, r_hi, c_lo, c_hi);
    int kh, kw, ph, pw, br, bc;
    kh = (kern_h > MAX_KERNEL) ? MAX_KERNEL : int'(kern_h);
    kw = (kern_w > MAX_KERNEL) ? MAX_KERNEL : int'(kern_w);
    ph = (rows_in > MAX_ROWS) ? MAX_ROWS : int'(rows_in);
    pw = (cols_in > MAX_COLS) ? MAX_COLS : int'(cols_in);
    br = int'(orow) * int'(step_r) - int'(pad_t);
    bc = int'(ocol) * int'(step_c) - int'(pad_l);
    r_lo = (br < 0) ? 0 : br;
    c_lo = (bc < 0) ? 0 : bc;
    r_hi = (br + kh > ph) ? ph : br + kh;
    c_hi = (bc + kw > pw) ? pw : bc + kw;
    if (r_hi < r_lo) r_hi = r_lo;
    if (c_hi < c_lo) c_hi = c_lo;
  endfunction

  // max or truncated average over the valid part of the window
  function automatic pool_result_t pool_window(logic [ACT_W-1:0] act,
                                               logic [POS_W-1:0] orow, ocol);
    pool_result_t res;
    int r_lo, r_hi, c_lo, c_hi, n;
    longint acc, s;
    clip_window(orow, ocol, r_lo, r_hi, c_lo, c_hi);
    n = (r_hi - r_lo) * (c_hi - c_lo);
    // empty window: max gives the most negative sample, average gives zero
    acc = (act == ACT_MAX) ? -(longint'(1) << (SAMPLE_BITS - 1)) : 0;
    for (int r = r_lo; r < r_hi; r++) begin
      for (int c = c_lo; c < c_hi; c++) begin
        s = plane_mem[r*MAX_COLS + c];
        if (act == ACT_MAX) begin
          if (s > acc) acc = s;
        end else begin
          acc += s;
        end
      end
    end
    // signed division truncates toward zero
    if (act == ACT_AVG && n != 0) acc = acc / n;
    res.value = acc[SAMPLE_BITS-1:0];
    res.count = n[COUNT_W-1:0];
    return res;
  endfunction

  // an accepted item updates the shadow plane or owes one pooled value
  function automatic void take_item(pool_item_t it);
    case (it.action)
      ACT_LOAD: begin
        plane_mem[{it.row, it.col}] = it.sample;
        loads_taken++;
      end
      ACT_MAX, ACT_AVG: pooled_q.push_back(pool_window(it.action, it.row, it.col));
      default: ;  // unused action, nothing happens
    endcase
    taken_count++;
  endfunction

  // driver: holds the item until it is taken, idles now and then
  always @(posedge clk) begin
    pool_item_t nxt;
    if (rst) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= ACT_LOAD;
      in_ch.row    <= '0;
      in_ch.col    <= '0;
      in_ch.sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        take_item('{in_ch.action, in_ch.row, in_ch.col, in_ch.sample});
      if (!in_ch.valid || in_ch.ready) begin
        if (send_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          nxt = send_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.action <= nxt.action;
          in_ch.row    <= nxt.row;
          in_ch.col    <= nxt.col;
          in_ch.sample <= nxt.sample;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each pooled value against the oldest one owed
  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pooled_q.size() == 0) begin
          $error("pooled value %0d count %0d with nothing owed",
                 $signed(out_ch.pooled_value), out_ch.valid_count);
          fail_count++;
        end else begin
          want = pooled_q.pop_front();
          pools_checked++;
          if (out_ch.pooled_value !== want.value) begin
            $error("pooled_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_ch.pooled_value));
            fail_count++;
          end
          if (out_ch.valid_count !== want.count) begin
            $error("valid_count: expected %0d, got %0d", want.count, out_ch.valid_count);
            fail_count++;
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(0, 99) >= 8;
    end
  end

  task automatic push_item(pool_item_t it);
    send_q.push_back(it);
    pushed_count++;
    if (it.action != ACT_UNUSED) stim_count++;
  endtask

  task automatic push_load(int r, int c, logic [SAMPLE_BITS-1:0] smp);
    push_item('{ACT_LOAD, r[POS_W-1:0], c[POS_W-1:0], smp});
    filled[r*MAX_COLS + c] = 1'b1;
  endtask

  // pool request preceded by loads for any window entry not yet written
  task automatic queue_pool(logic [ACT_W-1:0] act, logic [POS_W-1:0] orow, ocol);
    int r_lo, r_hi, c_lo, c_hi;
    clip_window(orow, ocol, r_lo, r_hi, c_lo, c_hi);
    for (int r = r_lo; r < r_hi; r++)
      for (int c = c_lo; c < c_hi; c++)
        if (!filled[r*MAX_COLS + c]) push_load(r, c, SAMPLE_BITS'($urandom()));
    push_item('{act, orow, ocol, SAMPLE_BITS'($urandom())});
  endtask

  // wait until every item is taken and every pooled value has come back
  task automatic drain();
    while (taken_count != pushed_count || pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KERNEL_H: kern_h  = data[KERN_W-1:0];
      REG_KERNEL_W: kern_w  = data[KERN_W-1:0];
      REG_STRIDE_R: step_r  = data[KERN_W-1:0];
      REG_STRIDE_C: step_c  = data[KERN_W-1:0];
      REG_PAD_TOP:  pad_t   = data[PAD_W-1:0];
      REG_PAD_LEFT: pad_l   = data[PAD_W-1:0];
      REG_PLANE_H:  rows_in = data;
      default:      cols_in = data;
    endcase
  endtask

  // write all eight registers; unused upper data bits get random junk
  task automatic set_config(int kh, kw, sr, sc, pt, pl, ph, pw);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    write_reg(REG_KERNEL_H, {junk[6:4], kh[3:0]});
    write_reg(REG_KERNEL_W, {junk[3:1], kw[3:0]});
    write_reg(REG_STRIDE_R, {junk[2:0], sr[3:0]});
    write_reg(REG_STRIDE_C, {junk[5:3], sc[3:0]});
    write_reg(REG_PAD_TOP,  {junk[6:3], pt[2:0]});
    write_reg(REG_PAD_LEFT, {junk[3:0], pl[2:0]});
    write_reg(REG_PLANE_H,  ph[6:0]);
    write_reg(REG_PLANE_W,  pw[6:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // legal range most of the time, whole field now and then
  function automatic int pick_field(int lo, hi, field_max);
    return ($urandom_range(0, 99) < 15) ? $urandom_range(0, field_max)
                                        : $urandom_range(lo, hi);
  endfunction

  // random traffic for one setting: mostly pool requests with their loads
  task automatic run_traffic(int span);
    int start, pick, lim_r, lim_c, ph, pw;
    logic [POS_W-1:0] orow, ocol;
    start = stim_count;
    ph = (rows_in > MAX_ROWS) ? MAX_ROWS : int'(rows_in);
    pw = (cols_in > MAX_COLS) ? MAX_COLS : int'(cols_in);
    // output positions whose window still touches the plane
    lim_r = (step_r == 0) ? 63 : (ph + int'(pad_t)) / int'(step_r);
    lim_c = (step_c == 0) ? 63 : (pw + int'(pad_l)) / int'(step_c);
    if (lim_r > 63) lim_r = 63;
    if (lim_c > 63) lim_c = 63;
    while (stim_count - start < span) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_item('{ACT_UNUSED, 6'($urandom()), 6'($urandom()), 16'($urandom())});
      end else if (pick < 18) begin
        push_load($urandom_range(0, 63), $urandom_range(0, 63), SAMPLE_BITS'($urandom()));
      end else begin
        if (pick < 85) begin
          orow = POS_W'($urandom_range(0, lim_r));
          ocol = POS_W'($urandom_range(0, lim_c));
        end else begin
          orow = POS_W'($urandom());
          ocol = POS_W'($urandom());
        end
        queue_pool(($urandom_range(0, 1) != 0) ? ACT_MAX : ACT_AVG, orow, ocol);
      end
    end
  endtask

  // stimulus
  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    // register values after reset
    kern_h = 4'd2; kern_w = 4'd2; step_r = 4'd2; step_c = 4'd2;
    pad_t = 3'd0; pad_l = 3'd0; rows_in = 7'd64; cols_in = 7'd64;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset setting (2x2 kernel, stride 2)
    // extremes of the sample: max and average of +max/-max mix
    push_load(0, 0, 16'h7FFF);
    push_load(0, 1, 16'h8000);
    push_load(1, 0, 16'h7FFF);
    push_load(1, 1, 16'hFFFF);
    queue_pool(ACT_MAX, 0, 0);
    queue_pool(ACT_AVG, 0, 0);
    // negative average must truncate toward zero, not round down
    push_load(2, 2, 16'hFFFD);
    push_load(2, 3, 16'h0000);
    push_load(3, 2, 16'h0000);
    push_load(3, 3, 16'h0000);
    queue_pool(ACT_AVG, 1, 1);
    queue_pool(ACT_MAX, 1, 1);
    // all-negative window in the far corner
    push_load(62, 62, 16'h8000);
    push_load(62, 63, 16'h8000);
    push_load(63, 62, 16'h8000);
    push_load(63, 63, 16'h8001);
    queue_pool(ACT_MAX, 31, 31);
    queue_pool(ACT_AVG, 31, 31);
    // window fully off the plane
    queue_pool(ACT_MAX, 40, 40);
    queue_pool(ACT_AVG, 63, 63);
    // ignored action
    push_item('{ACT_UNUSED, 6'd63, 6'd63, 16'hA5A5});
    // sender holds off here until every pooled value is back
    drain();

    // fixed extreme settings first, random ones after
    phase = 0;
    while (stim_count < ITEM_TARGET) begin
      case (phase)
        0: set_config(1, 1, 1, 1, 0, 0, 64, 64);        // smallest kernel
        1: set_config(8, 8, 8, 8, 7, 7, 64, 64);        // largest legal kernel and pad
        2: set_config(8, 8, 1, 1, 7, 7, 1, 1);          // single-sample plane
        3: set_config(15, 15, 0, 0, 0, 0, 127, 127);    // saturated kernel and plane, zero stride
        4: set_config(0, 3, 3, 0, 2, 5, 0, 40);         // zero kernel height, zero plane height
        5: set_config(3, 5, 15, 15, 3, 1, 64, 17);      // widest stride
        default: set_config(pick_field(1, 8, 15), pick_field(1, 8, 15),
                            pick_field(1, 8, 15), pick_field(1, 8, 15),
                            $urandom_range(0, 7), $urandom_range(0, 7),
                            pick_field(1, 64, 127), pick_field(1, 64, 127));
      endcase
      // one stretch (phase 1) with no idling on either side
      calm = (phase == 1);
      run_traffic(60);
      drain();
      phase++;
    end
    calm = 1'b0;

    $display("run covered %0d items (%0d loads) and %0d pooled values over %0d settings",
             taken_count, loads_taken, pools_checked, settings_done + 1);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/wpma_pkg.sv
rtl/core/wpma_in_if.sv
rtl/core/wpma_out_if.sv
rtl/core/wpma_ram.sv
rtl/core/wpma_div.sv
rtl/core/window_pool_max_avg.sv
tb/sv/testbench.sv
